// ----- design/scu_pkg.sv -----
// ----------------------------------------------------------------------------
// S-curve profile package
// Shared widths, segment codes, configuration register indexes and reset
// values for the S-curve step-rate profile block.
// ----------------------------------------------------------------------------
package scu_pkg;

	// Tick counts, jerk, phase lengths and timer scale are all 16 bits wide.
	localparam int CNT_W     = 16;
	// Serial multiplier operand and product widths.
	localparam int MCAND_W   = 32;
	localparam int PROD_W    = MCAND_W + CNT_W;
	// Signed frequency intermediate: holds +/- 2^48 plus a start frequency.
	localparam int FQ_W      = 50;
	// Signed acceleration intermediate and its clamped output width.
	localparam int AY_W      = 34;
	localparam int ACC_W     = 17;
	localparam int ACC_LIMIT = 65535;
	localparam int CFG_IDX_W = 3;

	typedef logic [2:0] seg_t;

	localparam seg_t SEG_JERK_UP   = 3'd0;
	localparam seg_t SEG_ACCEL     = 3'd1;
	localparam seg_t SEG_JERK_DOWN = 3'd2;
	localparam seg_t SEG_CRUISE    = 3'd3;
	localparam seg_t SEG_DECEL_UP  = 3'd4;
	localparam seg_t SEG_DECEL     = 3'd5;
	localparam seg_t SEG_FINAL     = 3'd6;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_JERK   = 3'd0;
	localparam cfg_idx_t CFG_PHASE0 = 3'd1;
	localparam cfg_idx_t CFG_PHASE1 = 3'd2;
	localparam cfg_idx_t CFG_PHASE2 = 3'd3;
	localparam cfg_idx_t CFG_CRUISE = 3'd4;
	localparam cfg_idx_t CFG_SCALE  = 3'd5;

	localparam logic [CNT_W-1:0] CNT_MAX    = '1;
	localparam logic [CNT_W-1:0] JERK_RST   = 16'd1;
	localparam logic [CNT_W-1:0] CRUISE_RST = 16'hFFFF;
	localparam logic [CNT_W-1:0] SCALE_RST  = 16'd1000;

endpackage

// ----- design/scu_mul.sv -----
// ----------------------------------------------------------------------------
// S-curve serial multiplier
// Unsigned shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module scu_mul #(
	parameter int A_W = 32,
	parameter int B_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);

	localparam int P_W      = A_W + B_W;
	localparam int CNT_BITS = $clog2(B_W + 1);

	logic [P_W-1:0]      prod_q;
	logic [A_W-1:0]      mcand_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [A_W:0]        sum;

	// The low half holds the multiplier; each cycle its low bit decides
	// whether the multiplicand is added to the high half, then all shifts right.
	assign sum = {1'b0, prod_q[P_W-1:B_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNT_BITS'(1));
			if (start) begin
				cnt_q <= CNT_BITS'(B_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q  <= {A_W'(0), b};
			mcand_q <= a;
		end else if (cnt_q != '0) begin
			prod_q <= {sum, prod_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ----- design/scu_div.sv -----
// ----------------------------------------------------------------------------
// S-curve serial divider
// Restoring divider that produces one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module scu_div #(
	parameter int DVD_W = 16,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quot
);

	localparam int CNT_BITS = $clog2(DVD_W + 1);

	logic [DVS_W-1:0]    rem_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [DVD_W-1:0]    quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [DVS_W:0]      trial;
	logic [DVS_W:0]      diff;
	logic                ge;

	// The dividend shifts out of the top of quo_q while quotient bits shift
	// in at the bottom.
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNT_BITS'(1));
			if (start) begin
				cnt_q <= CNT_BITS'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ----- design/s_curve_step_rate_profile.sv -----
// ----------------------------------------------------------------------------
// S-curve step-rate profile
// Per-axis seven-segment jerk-limited velocity profile driven by timer ticks.
// Each transfer on the input channel is one elapsed timer of one axis. The
// block advances that axis's tick count and either returns one result
// (frequency, acceleration, timer reload period and half-period compare) or,
// at the end of a segment, moves the axis to its next segment with no result.
// Configuration writes use their own channel, which is always ready; they are
// meant to happen while the block is idle. A tick that gives a result runs
// two passes of 16-step serial multiplication and then a 16-step serial
// division before its result is written to the output register and the
// block takes its next input; a zero frequency or a segment end skips the
// division. Ticks for an absent axis are dropped at the input transfer.
// Reset clears all axis state to the jerk-up segment and loads the
// register reset values. A result that the receiver stalls holds the output
// register; the next tick is still accepted and worked on, and only its final
// write waits for the output register to drain.
// ----------------------------------------------------------------------------
module s_curve_step_rate_profile #(
	parameter int NUM_AXES  = 3,
	parameter int FREQ_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  scu_pkg::cfg_idx_t                     cfg_index,
	input  logic [scu_pkg::CNT_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            axis,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            out_axis,
	output scu_pkg::seg_t                         segment,
	output logic [15:0]                           step_freq,
	output logic signed [scu_pkg::ACC_W-1:0]      accel,
	output logic [15:0]                           timer_period,
	output logic [14:0]                           timer_compare,
	output logic                                  clamped
);

	import scu_pkg::*;

	localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int FM_W = FQ_W - 1;
	localparam logic [FM_W-1:0] FREQ_MAX  = FM_W'((64'd1 << FREQ_BITS) - 64'd1);
	localparam logic [FM_W-1:0] START_MAX = FM_W'(CNT_MAX);
	localparam logic signed [AY_W-1:0] ACC_HI = AY_W'(ACC_LIMIT);
	localparam logic signed [AY_W-1:0] ACC_LO = -ACC_HI;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL1  = 8'b0000_0010,
		ST_MUL2  = 8'b0000_0100,
		ST_COMB  = 8'b0000_1000,
		ST_FREQ  = 8'b0001_0000,
		ST_CLAMP = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} st_t;

	st_t state_q, state_d;

	// Configuration registers.
	logic [CNT_W-1:0] jerk_q;
	logic [CNT_W-1:0] phase_q [NUM_AXES];
	logic [CNT_W-1:0] cruise_q;
	logic [CNT_W-1:0] scale_q;

	// Per-axis profile state.
	seg_t             segs_q    [NUM_AXES];
	logic [CNT_W-1:0] ticks_q   [NUM_AXES];
	logic [CNT_W-1:0] start_f_q [NUM_AXES];

	// Registers of the item in flight.
	logic [1:0]              item_axis_q;
	seg_t                    iseg_q;
	logic [CNT_W-1:0]        tinc_q;
	logic [CNT_W-1:0]        teval_q;
	logic [CNT_W-1:0]        f0_q;
	logic                    end_q;
	logic [MCAND_W-1:0]      p_q;
	logic [MCAND_W-1:0]      a_q;
	logic signed [FQ_W-1:0]  x_q;
	logic signed [AY_W-1:0]  y_q;
	logic signed [FQ_W-1:0]  f_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [FREQ_BITS-1:0]    fc_q;
	logic [CNT_W-1:0]        endf_q;
	logic                    clp_q;
	logic                    fz_q;

	// Output register.
	logic                    out_valid_q;
	logic [1:0]              out_axis_q;
	seg_t                    segment_q;
	logic [15:0]             step_freq_q;
	logic signed [ACC_W-1:0] accel_q;
	logic [15:0]             period_q;
	logic                    clamped_q;

	// ------------------------------------------------------------------
	// Configuration channel. Index 1 to 3 selects the phase length of one
	// axis; a write for an axis that is not built is dropped.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jerk_q   <= JERK_RST;
			cruise_q <= CRUISE_RST;
			scale_q  <= SCALE_RST;
			for (int i = 0; i < NUM_AXES; i++) begin
				phase_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_JERK: begin
					jerk_q <= cfg_data;
				end
				CFG_PHASE0, CFG_PHASE1, CFG_PHASE2: begin
					for (int i = 0; i < NUM_AXES; i++) begin
						if (int'(cfg_index - CFG_PHASE0) == i) begin
							phase_q[i] <= cfg_data;
						end
					end
				end
				CFG_CRUISE: begin
					cruise_q <= cfg_data;
				end
				CFG_SCALE: begin
					scale_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input transfer. The tick count is raised (saturating) and compared
	// with the segment length. The profile is evaluated at the raised count,
	// or at the segment length when the segment ends, since that value is
	// the next segment's start frequency.
	// ------------------------------------------------------------------
	logic [AX_W-1:0]  in_ax;
	logic             ax_ok;
	seg_t             in_seg;
	logic [CNT_W-1:0] in_ticks;
	logic [CNT_W-1:0] in_t_len;
	logic [CNT_W-1:0] in_tinc;
	logic [CNT_W-1:0] in_len;
	logic             in_end;
	logic [CNT_W-1:0] in_teval;
	logic             accept;
	logic             start1;

	assign in_ax    = AX_W'(axis);
	assign ax_ok    = int'(axis) < NUM_AXES;
	assign in_seg   = segs_q[in_ax];
	assign in_ticks = ticks_q[in_ax];
	assign in_t_len = phase_q[in_ax];
	assign in_tinc  = (in_ticks == CNT_MAX) ? CNT_MAX : in_ticks + CNT_W'(1);
	assign in_len   = (in_seg == SEG_CRUISE) ? cruise_q : in_t_len;
	assign in_end   = in_tinc >= in_len;
	assign in_teval = in_end ? in_len : in_tinc;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign start1   = accept && ax_ok;

	// ------------------------------------------------------------------
	// Two serial multipliers, used twice. First pass: J*t and A = J*T.
	// Second pass: (J*t)*t, which halved is H(t), and A*t.
	// ------------------------------------------------------------------
	logic               mul_start;
	logic [MCAND_W-1:0] mx_a, my_a;
	logic [CNT_W-1:0]   mx_b, my_b;
	logic               mx_done, my_done;
	logic [PROD_W-1:0]  mx_prod, my_prod;

	assign mul_start = start1 || ((state_q == ST_MUL1) && mx_done);
	assign mx_a = (state_q == ST_IDLE) ? MCAND_W'(jerk_q) : mx_prod[MCAND_W-1:0];
	assign my_a = (state_q == ST_IDLE) ? MCAND_W'(jerk_q) : my_prod[MCAND_W-1:0];
	assign mx_b = (state_q == ST_IDLE) ? in_teval : teval_q;
	assign my_b = (state_q == ST_IDLE) ? in_t_len : teval_q;

	scu_mul #(
		.A_W(MCAND_W),
		.B_W(CNT_W)
	) u_mul_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mx_a),
		.b     (mx_b),
		.done  (mx_done),
		.prod  (mx_prod)
	);

	scu_mul #(
		.A_W(MCAND_W),
		.B_W(CNT_W)
	) u_mul_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (my_a),
		.b     (my_b),
		.done  (my_done),
		.prod  (my_prod)
	);

	// ------------------------------------------------------------------
	// Segment arithmetic. The deceleration segments mirror the acceleration
	// ones, so one offset x (frequency) and y (acceleration) is formed per
	// segment pair and then added to or subtracted from the base.
	// ------------------------------------------------------------------
	logic signed [FQ_W-1:0] h_s, at_s, x_d, base, f_d;
	logic signed [AY_W-1:0] p_s, a_s, y_d, yv, acc_d;
	logic                   neg;

	assign h_s  = $signed(FQ_W'(mx_prod[PROD_W-1:1]));
	assign at_s = $signed(FQ_W'(my_prod));
	assign p_s  = $signed(AY_W'(p_q));
	assign a_s  = $signed(AY_W'(a_q));

	always_comb begin
		case (iseg_q)
			SEG_JERK_UP, SEG_DECEL_UP: begin
				x_d = h_s;
				y_d = p_s;
			end
			SEG_ACCEL, SEG_DECEL: begin
				x_d = at_s;
				y_d = a_s;
			end
			SEG_JERK_DOWN, SEG_FINAL: begin
				x_d = at_s - h_s;
				y_d = a_s - p_s;
			end
			default: begin
				x_d = '0;
				y_d = '0;
			end
		endcase
	end

	// The first segment starts from rest and ignores the stored start value.
	assign neg  = (iseg_q >= SEG_DECEL_UP);
	assign base = (iseg_q == SEG_JERK_UP) ? '0 : $signed(FQ_W'(f0_q));
	assign f_d  = neg ? base - x_q : base + x_q;
	assign yv   = neg ? -y_q : y_q;
	assign acc_d = (yv > ACC_HI) ? ACC_HI : ((yv < ACC_LO) ? ACC_LO : yv);

	// ------------------------------------------------------------------
	// Frequency clamps: one to the output range, one to the 16-bit range of
	// the stored start frequency.
	// ------------------------------------------------------------------
	logic                 f_neg;
	logic [FM_W-1:0]      f_mag;
	logic                 f_hi;
	logic [FREQ_BITS-1:0] fc_d;
	logic [CNT_W-1:0]     endf_d;
	logic                 fz_d;
	logic                 div_start;
	logic                 div_done;
	logic [CNT_W-1:0]     div_quot;

	assign f_neg  = f_q[FQ_W-1];
	assign f_mag  = f_q[FM_W-1:0];
	assign f_hi   = !f_neg && (f_mag > FREQ_MAX);
	assign fc_d   = f_neg ? '0 : (f_hi ? FREQ_BITS'(FREQ_MAX) : f_mag[FREQ_BITS-1:0]);
	assign endf_d = f_neg ? '0 : ((f_mag > START_MAX) ? CNT_MAX : f_mag[CNT_W-1:0]);
	assign fz_d   = (fc_d == '0);

	// The period is only computed for a nonzero frequency of a tick that
	// gives a result; a zero frequency saturates the period instead.
	assign div_start = (state_q == ST_CLAMP) && !end_q && !fz_d;

	scu_div #(
		.DVD_W(CNT_W),
		.DVS_W(FREQ_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(scale_q),
		.divisor (fc_d),
		.done    (div_done),
		.quot    (div_quot)
	);

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	logic fin_go;

	// A segment end has nothing to deliver; a result waits for the output
	// register to be free.
	assign fin_go = end_q || !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start1) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				if (mx_done) begin
					state_d = ST_MUL2;
				end
			end
			ST_MUL2: begin
				if (mx_done) begin
					state_d = ST_COMB;
				end
			end
			ST_COMB: begin
				state_d = ST_FREQ;
			end
			ST_FREQ: begin
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				state_d = (end_q || fz_d) ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		if (start1) begin
			item_axis_q <= axis;
			iseg_q      <= in_seg;
			tinc_q      <= in_tinc;
			teval_q     <= in_teval;
			f0_q        <= start_f_q[in_ax];
			end_q       <= in_end;
		end
		if ((state_q == ST_MUL1) && mx_done) begin
			p_q <= mx_prod[MCAND_W-1:0];
			a_q <= my_prod[MCAND_W-1:0];
		end
		if (state_q == ST_COMB) begin
			x_q <= x_d;
			y_q <= y_d;
		end
		if (state_q == ST_FREQ) begin
			f_q   <= f_d;
			acc_q <= acc_d[ACC_W-1:0];
		end
		if (state_q == ST_CLAMP) begin
			fc_q   <= fc_d;
			endf_q <= endf_d;
			clp_q  <= f_neg || f_hi;
			fz_q   <= fz_d;
		end
	end

	// ------------------------------------------------------------------
	// Per-axis state write-back at the end of the item. A segment end
	// clears the count, steps the segment and stores the start frequency
	// of the next segment, which is zero again after the final segment.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				segs_q[i]    <= SEG_JERK_UP;
				ticks_q[i]   <= '0;
				start_f_q[i] <= '0;
			end
		end else if ((state_q == ST_FIN) && fin_go) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				if (int'(item_axis_q) == i) begin
					if (end_q) begin
						ticks_q[i] <= '0;
						if (iseg_q == SEG_FINAL) begin
							segs_q[i]    <= SEG_JERK_UP;
							start_f_q[i] <= '0;
						end else begin
							segs_q[i]    <= seg_t'(iseg_q + 1'b1);
							start_f_q[i] <= endf_q;
						end
					end else begin
						ticks_q[i] <= tinc_q;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	logic load_out;

	assign load_out = (state_q == ST_FIN) && fin_go && !end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_axis_q  <= item_axis_q;
			segment_q   <= iseg_q;
			step_freq_q <= 16'(fc_q);
			accel_q     <= acc_q;
			period_q    <= fz_q ? CNT_MAX : div_quot;
			clamped_q   <= clp_q || fz_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_axis      = out_axis_q;
	assign segment       = segment_q;
	assign step_freq     = step_freq_q;
	assign accel         = accel_q;
	assign timer_period  = period_q;
	assign timer_compare = period_q[15:1];
	assign clamped       = clamped_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// Both multipliers are started together and must finish together.
	assert property (@(posedge clk) disable iff (!arst_n) mx_done == my_done)
		else $error("multipliers finished in different cycles");

	// A multiplier only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mx_done |-> (state_q == ST_MUL1 || state_q == ST_MUL2))
		else $error("multiplier finished outside a multiply state");

	// The divider only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// A result is never written over a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !end_q && out_valid_q && !out_ready) |=> (state_q == ST_FIN))
		else $error("result left the final state while the output was stalled");

	// A new result only appears from the final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("output became valid outside the final state");

endmodule
